### design/hsee_pkg.sv
// shared types and constants of the heisenberg spin energy engine
`timescale 1ns / 1ps
`default_nettype none
package hsee_pkg;

  localparam int MAX_SITES_DEF = 256;
  localparam int CNT_W         = 11;   // holds any site count up to 1024
  localparam int SITES_CFG_W   = 9;
  localparam logic [SITES_CFG_W-1:0] SITES_RESET = 9'd256;
  localparam int PROD_W        = 52;
  localparam int DOT_W         = 35;
  localparam int VEC_W         = 17;
  localparam int ENERGY_W      = 63;

  typedef enum logic [1:0] {
    OP_WR_SPIN = 2'd0,
    OP_WR_COUP = 2'd1,
    OP_DELTA   = 2'd2,
    OP_TOTAL   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    op_t                opcode;
    logic [7:0]         site;
    logic [7:0]         partner_site;
    logic signed [15:0] spin_x;
    logic signed [15:0] spin_y;
    logic signed [15:0] spin_z;
    logic signed [15:0] coupling_value;
  } req_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy_value;
    status_t                    status;
  } rsp_t;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } spin_vec_t;

  typedef enum logic [1:0] {
    MS_X,
    MS_Y,
    MS_Z,
    MS_J
  } mul_sel_t;

  typedef struct packed {
    logic     vec_ld;
    logic     vec_diff;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     dot_ld;
    logic     dot_add;
    logic     acc_clr;
    logic     acc_add;
    logic     acc_dbl;
  } dp_ctl_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDI,
    S_CAPI,
    S_RD,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_MJ,
    S_AC,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

### design/hsee_spin_mem.sv
// spin vector store, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module hsee_spin_mem #(
  parameter int MAX_SITES = hsee_pkg::MAX_SITES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(MAX_SITES)-1:0] waddr,
  input  wire hsee_pkg::spin_vec_t          wdata,
  input  wire logic                         re,
  input  wire logic [$clog2(MAX_SITES)-1:0] raddr,
  output hsee_pkg::spin_vec_t               rdata
);

  hsee_pkg::spin_vec_t mem [MAX_SITES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/hsee_coup_mem.sv
// coupling matrix store addressed by row and column
`timescale 1ns / 1ps
`default_nettype none
module hsee_coup_mem #(
  parameter int MAX_SITES = hsee_pkg::MAX_SITES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [2*$clog2(MAX_SITES)-1:0] waddr,
  input  wire logic signed [15:0]             wdata,
  input  wire logic                           re,
  input  wire logic [2*$clog2(MAX_SITES)-1:0] raddr,
  output logic signed [15:0]                  rdata
);

  localparam int DEPTH = 2 ** (2 * $clog2(MAX_SITES));

  logic signed [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/hsee_datapath.sv
// shared multiplier with dot and energy accumulators and saturation
`timescale 1ns / 1ps
`default_nettype none
module hsee_datapath #(
  parameter int MAX_SITES = hsee_pkg::MAX_SITES_DEF
) (
  input  wire logic                                   clk,
  input  wire hsee_pkg::dp_ctl_t                      ctl,
  input  wire hsee_pkg::spin_vec_t                    prop_spin,
  input  wire hsee_pkg::spin_vec_t                    spin_rd,
  input  wire logic signed [15:0]                     coup_rd,
  output logic signed [hsee_pkg::ENERGY_W-1:0]        energy,
  output logic                                        sat
);

  localparam int IW       = $clog2(MAX_SITES);
  localparam int ACCW_RAW = hsee_pkg::PROD_W + 2 * IW + 1;
  localparam int ACCW     = (ACCW_RAW > 64) ? ACCW_RAW : 64;
  localparam int EW       = hsee_pkg::ENERGY_W;

  logic signed [hsee_pkg::VEC_W-1:0]  vec_x, vec_y, vec_z;
  logic signed [hsee_pkg::PROD_W-1:0] prod;
  logic signed [hsee_pkg::DOT_W-1:0]  dot;
  logic signed [ACCW-1:0]             acc;
  logic signed [hsee_pkg::DOT_W-1:0]  mul_a;
  logic signed [hsee_pkg::VEC_W-1:0]  mul_b;
  logic signed [ACCW-1:0]             addend;
  logic                               fits;

  always_comb begin
    case (ctl.mul_sel)
      hsee_pkg::MS_X: begin
        mul_a = hsee_pkg::DOT_W'(spin_rd.x);
        mul_b = vec_x;
      end
      hsee_pkg::MS_Y: begin
        mul_a = hsee_pkg::DOT_W'(spin_rd.y);
        mul_b = vec_y;
      end
      hsee_pkg::MS_Z: begin
        mul_a = hsee_pkg::DOT_W'(spin_rd.z);
        mul_b = vec_z;
      end
      hsee_pkg::MS_J: begin
        mul_a = dot;
        mul_b = hsee_pkg::VEC_W'(coup_rd);
      end
      default: begin
        mul_a = dot;
        mul_b = hsee_pkg::VEC_W'(coup_rd);
      end
    endcase
  end

  // energy change counts every pair twice
  assign addend = ctl.acc_dbl ? (ACCW'(prod) <<< 1) : ACCW'(prod);

  always_ff @(posedge clk) begin
    if (ctl.vec_ld) begin
      if (ctl.vec_diff) begin
        vec_x <= hsee_pkg::VEC_W'(prop_spin.x) - hsee_pkg::VEC_W'(spin_rd.x);
        vec_y <= hsee_pkg::VEC_W'(prop_spin.y) - hsee_pkg::VEC_W'(spin_rd.y);
        vec_z <= hsee_pkg::VEC_W'(prop_spin.z) - hsee_pkg::VEC_W'(spin_rd.z);
      end else begin
        vec_x <= hsee_pkg::VEC_W'(spin_rd.x);
        vec_y <= hsee_pkg::VEC_W'(spin_rd.y);
        vec_z <= hsee_pkg::VEC_W'(spin_rd.z);
      end
    end
    if (ctl.mul_en) begin
      prod <= hsee_pkg::PROD_W'(mul_a) * hsee_pkg::PROD_W'(mul_b);
    end
    if (ctl.dot_ld) begin
      dot <= hsee_pkg::DOT_W'(prod);
    end else if (ctl.dot_add) begin
      dot <= dot + hsee_pkg::DOT_W'(prod);
    end
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.acc_add) begin
      acc <= acc + addend;
    end
  end

  // value fits when the sign bit of the result and all bits above it agree
  assign fits = (&acc[ACCW-1:EW-1]) || !(|acc[ACCW-1:EW-1]);
  assign sat  = !fits;

  always_comb begin
    if (fits) begin
      energy = acc[EW-1:0];
    end else if (acc[ACCW-1]) begin
      energy = {1'b1, {(EW-1){1'b0}}};
    end else begin
      energy = {1'b0, {(EW-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

### design/hsee_seq.sv
// sequencer: item handshake, site loops, store access and result register
`timescale 1ns / 1ps
`default_nettype none
module hsee_seq #(
  parameter int MAX_SITES = hsee_pkg::MAX_SITES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [hsee_pkg::CNT_W-1:0]     n,
  input  wire logic                           req_valid,
  output logic                                req_ready,
  input  wire hsee_pkg::req_t                 req,
  output logic                                rsp_valid,
  input  wire logic                           rsp_ready,
  output hsee_pkg::rsp_t                      rsp,
  output logic                                spin_we,
  output logic [$clog2(MAX_SITES)-1:0]        spin_waddr,
  output hsee_pkg::spin_vec_t                 spin_wdata,
  output logic                                spin_re,
  output logic [$clog2(MAX_SITES)-1:0]        spin_raddr,
  output logic                                coup_we,
  output logic [2*$clog2(MAX_SITES)-1:0]      coup_waddr,
  output logic signed [15:0]                  coup_wdata,
  output logic                                coup_re,
  output logic [2*$clog2(MAX_SITES)-1:0]      coup_raddr,
  output hsee_pkg::dp_ctl_t                   dp_ctl,
  output hsee_pkg::spin_vec_t                 prop_spin,
  input  wire logic signed [hsee_pkg::ENERGY_W-1:0] dp_energy,
  input  wire logic                           dp_sat
);

  localparam int IW = $clog2(MAX_SITES);
  localparam int CW = hsee_pkg::CNT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SITES - 1);

  hsee_pkg::state_t state, state_next;
  hsee_pkg::req_t   cur;
  logic [IW-1:0]    i, i_next, j, j_next, clr_idx, clr_idx_next;
  logic             err, err_next;
  logic             accept, req_err, j_last, i_last, is_delta, rsp_load;
  logic [IW-1:0]    site_i, req_site_i, req_part_i;

  assign accept     = req_valid && req_ready;
  assign req_ready  = (state == hsee_pkg::S_IDLE);
  assign is_delta   = (cur.opcode == hsee_pkg::OP_DELTA);
  assign site_i     = IW'(cur.site);
  assign req_site_i = IW'(req.site);
  assign req_part_i = IW'(req.partner_site);
  assign j_last     = (CW'(j) == n - CW'(1));
  assign i_last     = (CW'(i) == n - CW'(1));
  assign req_err    = (req.opcode != hsee_pkg::OP_TOTAL) &&
                      ((CW'(req.site) >= n) ||
                       ((req.opcode == hsee_pkg::OP_WR_COUP) &&
                        (CW'(req.partner_site) >= n)));
  assign rsp_load   = (state == hsee_pkg::S_DONE) && (!rsp_valid || rsp_ready);
  assign prop_spin  = '{z: cur.spin_z, y: cur.spin_y, x: cur.spin_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hsee_pkg::S_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i   <= i_next;
    j   <= j_next;
    err <= err_next;
    if (accept) begin
      cur <= req;
    end
    if (rsp_load) begin
      if (err) begin
        rsp.energy_value <= '0;
        rsp.status       <= hsee_pkg::ST_RANGE;
      end else begin
        rsp.energy_value <= dp_energy;
        rsp.status       <= dp_sat ? hsee_pkg::ST_SAT : hsee_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    state_next   = state;
    i_next       = i;
    j_next       = j;
    clr_idx_next = clr_idx;
    err_next     = err;
    spin_we      = 1'b0;
    spin_waddr   = req_site_i;
    spin_wdata   = '{z: req.spin_z, y: req.spin_y, x: req.spin_x};
    spin_re      = 1'b0;
    spin_raddr   = j;
    coup_we      = 1'b0;
    coup_waddr   = {req_site_i, req_part_i};
    coup_wdata   = req.coupling_value;
    coup_re      = 1'b0;
    coup_raddr   = is_delta ? {j, site_i} : {i, j};
    dp_ctl       = '{vec_ld: 1'b0, vec_diff: is_delta, mul_en: 1'b0,
                     mul_sel: hsee_pkg::MS_X, dot_ld: 1'b0, dot_add: 1'b0,
                     acc_clr: 1'b0, acc_add: 1'b0, acc_dbl: is_delta};
    case (state)
      hsee_pkg::S_CLEAR: begin
        spin_we      = 1'b1;
        spin_waddr   = clr_idx;
        spin_wdata   = '0;
        clr_idx_next = clr_idx + IW'(1);
        if (clr_idx == LAST_IDX) begin
          state_next = hsee_pkg::S_IDLE;
        end
      end
      hsee_pkg::S_IDLE: begin
        if (accept) begin
          dp_ctl.acc_clr = 1'b1;
          err_next       = req_err;
          i_next         = '0;
          j_next         = '0;
          state_next     = hsee_pkg::S_DONE;
          if (!req_err) begin
            case (req.opcode)
              hsee_pkg::OP_WR_SPIN: spin_we = 1'b1;
              hsee_pkg::OP_WR_COUP: coup_we = 1'b1;
              hsee_pkg::OP_DELTA:   state_next = hsee_pkg::S_RDI;
              hsee_pkg::OP_TOTAL: begin
                if (n != '0) begin
                  state_next = hsee_pkg::S_RDI;
                end
              end
              default: state_next = hsee_pkg::S_DONE;
            endcase
          end
        end
      end
      hsee_pkg::S_RDI: begin
        spin_re    = 1'b1;
        spin_raddr = is_delta ? site_i : i;
        j_next     = '0;
        state_next = hsee_pkg::S_CAPI;
      end
      hsee_pkg::S_CAPI: begin
        dp_ctl.vec_ld = 1'b1;
        state_next    = hsee_pkg::S_RD;
      end
      hsee_pkg::S_RD: begin
        if (is_delta && (j == site_i)) begin
          // self term cancels, skip the site
          if (j_last) begin
            state_next = hsee_pkg::S_DONE;
          end else begin
            j_next = j + IW'(1);
          end
        end else begin
          spin_re    = 1'b1;
          coup_re    = 1'b1;
          state_next = hsee_pkg::S_M0;
        end
      end
      hsee_pkg::S_M0: begin
        dp_ctl.mul_en  = 1'b1;
        dp_ctl.mul_sel = hsee_pkg::MS_X;
        state_next     = hsee_pkg::S_M1;
      end
      hsee_pkg::S_M1: begin
        dp_ctl.mul_en  = 1'b1;
        dp_ctl.mul_sel = hsee_pkg::MS_Y;
        dp_ctl.dot_ld  = 1'b1;
        state_next     = hsee_pkg::S_M2;
      end
      hsee_pkg::S_M2: begin
        dp_ctl.mul_en  = 1'b1;
        dp_ctl.mul_sel = hsee_pkg::MS_Z;
        dp_ctl.dot_add = 1'b1;
        state_next     = hsee_pkg::S_M3;
      end
      hsee_pkg::S_M3: begin
        dp_ctl.dot_add = 1'b1;
        state_next     = hsee_pkg::S_MJ;
      end
      hsee_pkg::S_MJ: begin
        dp_ctl.mul_en  = 1'b1;
        dp_ctl.mul_sel = hsee_pkg::MS_J;
        state_next     = hsee_pkg::S_AC;
      end
      hsee_pkg::S_AC: begin
        dp_ctl.acc_add = 1'b1;
        if (!j_last) begin
          j_next     = j + IW'(1);
          state_next = hsee_pkg::S_RD;
        end else if (!is_delta && !i_last) begin
          i_next     = i + IW'(1);
          state_next = hsee_pkg::S_RDI;
        end else begin
          state_next = hsee_pkg::S_DONE;
        end
      end
      hsee_pkg::S_DONE: begin
        if (rsp_load) begin
          state_next = hsee_pkg::S_IDLE;
        end
      end
      default: state_next = hsee_pkg::S_IDLE;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req_ready)
    else $error("item taken while previous item still in work");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == hsee_pkg::ST_RANGE) |-> (rsp.energy_value == '0))
    else $error("range error result carries nonzero energy");

  a_loop_bound: assert property (@(posedge clk) disable iff (rst)
    (state == hsee_pkg::S_RD) |-> (CW'(j) < n))
    else $error("site loop ran past active count");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == hsee_pkg::S_CLEAR) |-> !req_ready)
    else $error("item taken during spin store clear");

endmodule
`default_nettype wire

### design/heisenberg_spin_energy_engine_top.sv
// top level of the heisenberg spin energy engine
`timescale 1ns / 1ps
`default_nettype none
// usage
//   req channel (req_valid/req_ready/req) carries one item: an opcode with
//   site, partner site, proposed spin and coupling value; rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one result item per request
//   cfg channel writes sites_in_use (always ready); write it only while idle
// sequencing
//   spin or coupling write, or range error: goes from accept straight
//   to the result register; energy change query (n = active site count):
//   loops over the n sites but the queried one; total energy: all n*n pairs
//   every product goes through the one shared multiplier; each site pair
//   takes these steps in order: read, three spin products, dot sum,
//   coupling product, accumulate
// throughput
//   one item at a time; req_ready is high only when the sequencer is idle
//   a finished result sits in the output register, so the next item is
//   taken even while the receiver stalls; a further result waits until
//   the register drains
// reset
//   synchronous rst clears control and sets sites_in_use to 256, then a
//   clearing pass zeroes all MAX_SITES entries of the spin store; no item is
//   accepted during it. couplings stay undefined until written
module heisenberg_spin_energy_engine_top #(
  parameter int MAX_SITES = hsee_pkg::MAX_SITES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_ready,
  input  wire hsee_pkg::req_t                    req,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_ready,
  output hsee_pkg::rsp_t                         rsp,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hsee_pkg::SITES_CFG_W-1:0]  cfg_data
);

  localparam int IW = $clog2(MAX_SITES);
  localparam int CW = hsee_pkg::CNT_W;

  logic [hsee_pkg::SITES_CFG_W-1:0] sites_in_use;
  logic [CW-1:0]                    n;

  logic                             spin_we, spin_re, coup_we, coup_re;
  logic [IW-1:0]                    spin_waddr, spin_raddr;
  logic [2*IW-1:0]                  coup_waddr, coup_raddr;
  hsee_pkg::spin_vec_t              spin_wdata, spin_rd, prop_spin;
  logic signed [15:0]               coup_wdata, coup_rd;
  hsee_pkg::dp_ctl_t                dp_ctl;
  logic signed [hsee_pkg::ENERGY_W-1:0] dp_energy;
  logic                             dp_sat;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sites_in_use <= hsee_pkg::SITES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sites_in_use <= cfg_data;
    end
  end

  // active count clamps at the store size
  assign n = (CW'(sites_in_use) > CW'(MAX_SITES)) ? CW'(MAX_SITES)
                                                   : CW'(sites_in_use);

  hsee_seq #(.MAX_SITES(MAX_SITES)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .n          (n),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .spin_we    (spin_we),
    .spin_waddr (spin_waddr),
    .spin_wdata (spin_wdata),
    .spin_re    (spin_re),
    .spin_raddr (spin_raddr),
    .coup_we    (coup_we),
    .coup_waddr (coup_waddr),
    .coup_wdata (coup_wdata),
    .coup_re    (coup_re),
    .coup_raddr (coup_raddr),
    .dp_ctl     (dp_ctl),
    .prop_spin  (prop_spin),
    .dp_energy  (dp_energy),
    .dp_sat     (dp_sat)
  );

  hsee_spin_mem #(.MAX_SITES(MAX_SITES)) u_spin_mem (
    .clk   (clk),
    .we    (spin_we),
    .waddr (spin_waddr),
    .wdata (spin_wdata),
    .re    (spin_re),
    .raddr (spin_raddr),
    .rdata (spin_rd)
  );

  hsee_coup_mem #(.MAX_SITES(MAX_SITES)) u_coup_mem (
    .clk   (clk),
    .we    (coup_we),
    .waddr (coup_waddr),
    .wdata (coup_wdata),
    .re    (coup_re),
    .raddr (coup_raddr),
    .rdata (coup_rd)
  );

  hsee_datapath #(.MAX_SITES(MAX_SITES)) u_datapath (
    .clk       (clk),
    .ctl       (dp_ctl),
    .prop_spin (prop_spin),
    .spin_rd   (spin_rd),
    .coup_rd   (coup_rd),
    .energy    (dp_energy),
    .sat       (dp_sat)
  );

endmodule
`default_nettype wire
